// ----- rtl/core/bale_pkg.sv -----
// ----------------------------------------------------------------------------
// bale_pkg
// Shared types and constants of the bounded array list engine: command codes,
// sequencer states, field widths and the result status group.
// ----------------------------------------------------------------------------
`default_nettype none

package bale_pkg;

	// default sizes of the list storage
	localparam int DEPTH_DEF        = 16;
	localparam int KEY_BITS_DEF     = 64;
	localparam int PAYLOAD_BITS_DEF = 32;

	// fixed widths of the port fields
	localparam int CMD_W     = 3;
	localparam int POS_W     = 4;
	localparam int KEY_W     = 64;
	localparam int PAY_W     = 32;
	localparam int COUNT_W   = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 3'd0,
		CMD_DELETE = 3'd1,
		CMD_UPDATE = 3'd2,
		CMD_READ   = 3'd3,
		CMD_FIND   = 3'd4
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_INS_RD,
		ST_INS_WR,
		ST_INS_PUT,
		ST_DEL_RD,
		ST_DEL_WR,
		ST_DEL_END,
		ST_UPD,
		ST_RD_WAIT,
		ST_FIND_RD,
		ST_FIND_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               ok;
		logic [POS_W-1:0]   rpos;
		logic [COUNT_W-1:0] count;
		logic               empty;
	} status_t;

endpackage

`default_nettype wire

// ----- rtl/core/bale_store.sv -----
// ----------------------------------------------------------------------------
// bale_store
// Entry memory of the list: one word per position holding key and payload,
// one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bale_store #(
	parameter int DEPTH        = bale_pkg::DEPTH_DEF,
	parameter int KEY_BITS     = bale_pkg::KEY_BITS_DEF,
	parameter int PAYLOAD_BITS = bale_pkg::PAYLOAD_BITS_DEF,
	localparam int AW          = $clog2(DEPTH),
	localparam int WW          = KEY_BITS + PAYLOAD_BITS
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [WW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [WW-1:0] rdata
);

	logic [WW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/bale_ctrl.sv -----
// ----------------------------------------------------------------------------
// bale_ctrl
// Command sequencer: walks the entry memory one position at a time to shift
// entries for insert and delete, scans keys for find, and keeps the count.
// ----------------------------------------------------------------------------
`default_nettype none

module bale_ctrl #(
	parameter int DEPTH        = bale_pkg::DEPTH_DEF,
	parameter int KEY_BITS     = bale_pkg::KEY_BITS_DEF,
	parameter int PAYLOAD_BITS = bale_pkg::PAYLOAD_BITS_DEF,
	localparam int AW          = $clog2(DEPTH),
	localparam int WW          = KEY_BITS + PAYLOAD_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// item beat
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [bale_pkg::CMD_W-1:0]     command,
	input  wire logic [bale_pkg::POS_W-1:0]     position,
	input  wire logic                           append,
	input  wire logic [bale_pkg::KEY_W-1:0]     item_key,
	input  wire logic [bale_pkg::PAY_W-1:0]     item_payload,
	// result handoff
	output logic                                res_valid,
	input  wire logic                           res_ready,
	output bale_pkg::status_t                   res_status,
	output logic      [KEY_BITS-1:0]            res_key,
	output logic      [PAYLOAD_BITS-1:0]        res_pay,
	// entry memory
	output logic                                mem_we,
	output logic      [AW-1:0]                  mem_waddr,
	output logic      [WW-1:0]                  mem_wdata,
	output logic      [AW-1:0]                  mem_raddr,
	input  wire logic [WW-1:0]                  mem_rdata
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = CNT_W + bale_pkg::POS_W;
	localparam int PW_X  = (PAYLOAD_BITS > bale_pkg::PAY_W) ? PAYLOAD_BITS : bale_pkg::PAY_W;

	bale_pkg::state_t state_q, state_d;
	bale_pkg::cmd_t   cmd_q;

	logic [CNT_W-1:0]        occ_q;
	logic [CNT_W-1:0]        q_q;
	logic [CMP_W-1:0]        pos_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;

	logic                    ok_q;
	logic [bale_pkg::POS_W-1:0] rpos_q;
	logic [KEY_BITS-1:0]     rkey_q;
	logic [PAYLOAD_BITS-1:0] rpay_q;

	logic [CMP_W-1:0] occ_x, q_x, depth_x;
	logic [KEY_BITS-1:0]     rd_key;
	logic [PAYLOAD_BITS-1:0] rd_pay;
	logic                    key_hit;
	logic                    pos_in_list;
	logic [PW_X-1:0]         pay_x;

	assign occ_x       = CMP_W'(occ_q);
	assign q_x         = CMP_W'(q_q);
	assign depth_x     = CMP_W'(DEPTH);
	assign rd_key      = mem_rdata[WW-1 -: KEY_BITS];
	assign rd_pay      = mem_rdata[PAYLOAD_BITS-1:0];
	assign key_hit     = (rd_key == key_q);
	assign pos_in_list = (pos_q < occ_x);
	assign pay_x       = PW_X'(item_payload);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bale_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = bale_pkg::ST_EXEC;
				end
			end
			bale_pkg::ST_EXEC: begin
				unique case (cmd_q)
					bale_pkg::CMD_INSERT: begin
						if (occ_x < depth_x && pos_q <= occ_x) begin
							state_d = (occ_x > pos_q) ? bale_pkg::ST_INS_RD : bale_pkg::ST_INS_PUT;
						end else begin
							state_d = bale_pkg::ST_DONE;
						end
					end
					bale_pkg::CMD_DELETE: begin
						if (pos_in_list) begin
							state_d = (pos_q + CMP_W'(1) < occ_x) ? bale_pkg::ST_DEL_RD
								: bale_pkg::ST_DEL_END;
						end else begin
							state_d = bale_pkg::ST_DONE;
						end
					end
					bale_pkg::CMD_UPDATE: begin
						state_d = pos_in_list ? bale_pkg::ST_UPD : bale_pkg::ST_DONE;
					end
					bale_pkg::CMD_READ: begin
						state_d = pos_in_list ? bale_pkg::ST_RD_WAIT : bale_pkg::ST_DONE;
					end
					bale_pkg::CMD_FIND: begin
						state_d = (occ_q != '0) ? bale_pkg::ST_FIND_RD : bale_pkg::ST_DONE;
					end
					default: begin
						state_d = bale_pkg::ST_DONE;
					end
				endcase
			end
			bale_pkg::ST_INS_RD:  state_d = bale_pkg::ST_INS_WR;
			bale_pkg::ST_INS_WR: begin
				state_d = (q_x - CMP_W'(1) > pos_q) ? bale_pkg::ST_INS_RD : bale_pkg::ST_INS_PUT;
			end
			bale_pkg::ST_INS_PUT: state_d = bale_pkg::ST_DONE;
			bale_pkg::ST_DEL_RD:  state_d = bale_pkg::ST_DEL_WR;
			bale_pkg::ST_DEL_WR: begin
				state_d = (q_x + CMP_W'(2) < occ_x) ? bale_pkg::ST_DEL_RD : bale_pkg::ST_DEL_END;
			end
			bale_pkg::ST_DEL_END: state_d = bale_pkg::ST_DONE;
			bale_pkg::ST_UPD:     state_d = bale_pkg::ST_DONE;
			bale_pkg::ST_RD_WAIT: state_d = bale_pkg::ST_DONE;
			bale_pkg::ST_FIND_RD: state_d = bale_pkg::ST_FIND_CMP;
			bale_pkg::ST_FIND_CMP: begin
				if (key_hit || q_x + CMP_W'(1) >= occ_x) begin
					state_d = bale_pkg::ST_DONE;
				end else begin
					state_d = bale_pkg::ST_FIND_RD;
				end
			end
			bale_pkg::ST_DONE: begin
				if (res_ready) begin
					state_d = bale_pkg::ST_IDLE;
				end
			end
			default: state_d = bale_pkg::ST_IDLE;
		endcase
	end

	// memory strobes and handshake
	always_comb begin
		in_stall  = 1'b1;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = AW'(q_q);
		mem_wdata = mem_rdata;
		mem_raddr = AW'(q_q);
		unique case (state_q)
			bale_pkg::ST_IDLE: in_stall = 1'b0;
			bale_pkg::ST_EXEC: mem_raddr = AW'(pos_q);
			bale_pkg::ST_INS_RD: mem_raddr = AW'(q_q - CNT_W'(1));
			bale_pkg::ST_INS_WR: mem_we = 1'b1;
			bale_pkg::ST_INS_PUT, bale_pkg::ST_UPD: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(pos_q);
				mem_wdata = {key_q, pay_q};
			end
			bale_pkg::ST_DEL_RD: mem_raddr = AW'(q_q + CNT_W'(1));
			bale_pkg::ST_DEL_WR: mem_we = 1'b1;
			bale_pkg::ST_DONE: res_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bale_pkg::ST_IDLE;
			occ_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == bale_pkg::ST_INS_PUT) begin
				occ_q <= occ_q + CNT_W'(1);
			end else if (state_q == bale_pkg::ST_DEL_END) begin
				occ_q <= occ_q - CNT_W'(1);
			end
		end
	end

	// item capture and walk pointer
	always_ff @(posedge clk) begin
		unique case (state_q)
			bale_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd_q <= bale_pkg::cmd_t'(command);
					// append targets the current end of the list
					if (bale_pkg::cmd_t'(command) == bale_pkg::CMD_INSERT && append) begin
						pos_q <= occ_x;
					end else begin
						pos_q <= CMP_W'(position);
					end
					key_q <= item_key[KEY_BITS-1:0];
					pay_q <= pay_x[PAYLOAD_BITS-1:0];
				end
			end
			bale_pkg::ST_EXEC: begin
				ok_q   <= 1'b0;
				rpos_q <= (cmd_q == bale_pkg::CMD_FIND) ? '0 : pos_q[bale_pkg::POS_W-1:0];
				rkey_q <= '0;
				rpay_q <= '0;
				if (cmd_q == bale_pkg::CMD_INSERT) begin
					q_q <= occ_q;
				end else if (cmd_q == bale_pkg::CMD_DELETE) begin
					q_q <= CNT_W'(pos_q);
				end else begin
					q_q <= '0;
				end
			end
			bale_pkg::ST_INS_WR: q_q <= q_q - CNT_W'(1);
			bale_pkg::ST_DEL_WR: q_q <= q_q + CNT_W'(1);
			bale_pkg::ST_INS_PUT, bale_pkg::ST_DEL_END, bale_pkg::ST_UPD: ok_q <= 1'b1;
			bale_pkg::ST_RD_WAIT: begin
				ok_q   <= 1'b1;
				rkey_q <= rd_key;
				rpay_q <= rd_pay;
			end
			bale_pkg::ST_FIND_CMP: begin
				if (key_hit) begin
					ok_q   <= 1'b1;
					rpos_q <= q_x[bale_pkg::POS_W-1:0];
					rkey_q <= rd_key;
					rpay_q <= rd_pay;
				end else begin
					q_q <= q_q + CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	assign res_status.ok    = ok_q;
	assign res_status.rpos  = rpos_q;
	assign res_status.count = occ_x[bale_pkg::COUNT_W-1:0];
	assign res_status.empty = (occ_q == '0);
	assign res_key          = rkey_q;
	assign res_pay          = rpay_q;

endmodule

`default_nettype wire

// ----- rtl/core/bounded_array_list_engine_unit.sv -----
// ----------------------------------------------------------------------------
// bounded_array_list_engine_unit
// Ordered list of up to DEPTH key/payload entries with insert, append,
// delete, update, read and find-by-key commands.
//
// The input channel takes one command beat (in_valid/in_stall); the output
// channel gives one result beat per command (out_valid/out_stall). The block
// works on one command at a time and holds in_stall high until that command
// has handed its result to the output register. Every memory access goes
// through a single read port and a single write port, so a command moves
// or scans entries one position at a time:
//   update, read, rejected or unknown command: no entries walked
//   insert at p with count n:  entries n-1 down to p each move up by one
//   delete at p with count n:  entries p+1 to n-1 each move down by one
//   find:                      keys are read from index 0 until a match or the end
// The result appears on out_valid the cycle after the command hands it over and
// the next command can be taken in that same cycle. When the receiver stalls,
// the result holds in the output register; the next command is still taken
// and runs, then waits for the register to drain. Reset empties the list and
// clears out_valid; entry storage needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_array_list_engine_unit #(
	parameter int DEPTH        = bale_pkg::DEPTH_DEF,
	parameter int KEY_BITS     = bale_pkg::KEY_BITS_DEF,
	parameter int PAYLOAD_BITS = bale_pkg::PAYLOAD_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [bale_pkg::CMD_W-1:0]     command,
	input  wire logic [bale_pkg::POS_W-1:0]     position,
	input  wire logic                           append,
	input  wire logic [bale_pkg::KEY_W-1:0]     item_key,
	input  wire logic [bale_pkg::PAY_W-1:0]     item_payload,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                accepted,
	output logic      [bale_pkg::POS_W-1:0]     result_position,
	output logic      [bale_pkg::KEY_W-1:0]     out_key,
	output logic      [bale_pkg::PAY_W-1:0]     out_payload,
	output logic      [bale_pkg::COUNT_W-1:0]   entry_count,
	output logic                                list_empty
);

	localparam int AW   = $clog2(DEPTH);
	localparam int WW   = KEY_BITS + PAYLOAD_BITS;
	localparam int PW_X = (PAYLOAD_BITS > bale_pkg::PAY_W) ? PAYLOAD_BITS : bale_pkg::PAY_W;

	logic                    res_valid;
	logic                    res_ready;
	bale_pkg::status_t       res_status;
	logic [KEY_BITS-1:0]     res_key;
	logic [PAYLOAD_BITS-1:0] res_pay;
	logic [PW_X-1:0]         res_pay_x;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [WW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [WW-1:0] mem_rdata;

	bale_ctrl #(
		.DEPTH        (DEPTH),
		.KEY_BITS     (KEY_BITS),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.position     (position),
		.append       (append),
		.item_key     (item_key),
		.item_payload (item_payload),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res_status   (res_status),
		.res_key      (res_key),
		.res_pay      (res_pay),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	bale_store #(
		.DEPTH        (DEPTH),
		.KEY_BITS     (KEY_BITS),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register: free when empty or draining this cycle
	assign res_ready = !out_valid || !out_stall;
	assign res_pay_x = PW_X'(res_pay);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_ready) begin
			out_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			accepted        <= res_status.ok;
			result_position <= res_status.rpos;
			out_key         <= bale_pkg::KEY_W'(res_key);
			out_payload     <= res_pay_x[bale_pkg::PAY_W-1:0];
			entry_count     <= res_status.count;
			list_empty      <= res_status.empty;
		end
	end

endmodule

`default_nettype wire
